// ----- hw/rtl/u8wd_pkg.sv -----
package u8wd_pkg;

    // Decoded values
    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [20:0] MAX_SCALAR       = 21'h10FFFF;
    localparam logic [20:0] SURR_LO          = 21'h00D800;
    localparam logic [20:0] SURR_HI          = 21'h00DFFF;

    // Continuation byte bounds
    localparam logic [7:0] TRAIL_LO      = 8'h80;
    localparam logic [7:0] TRAIL_HI      = 8'hBF;
    localparam logic [7:0] TRAIL_LO_E0   = 8'hA0;
    localparam logic [7:0] TRAIL_HI_ED   = 8'h9F;
    localparam logic [7:0] TRAIL_LO_F0   = 8'h90;
    localparam logic [7:0] TRAIL_HI_F4   = 8'h8F;

    // Lead byte codes
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] LEAD_F0       = 8'hF0;
    localparam logic [7:0] LEAD_F4       = 8'hF4;
    localparam logic [7:0] LEAD_MIN_OK   = 8'hC2;
    localparam logic [7:0] LEAD_MAX_OK   = 8'hF4;
    localparam logic [7:0] CONT_FIRST    = 8'h80;

    localparam int unsigned NUM_LANES = 3;

    // Result of one continuation-byte lane
    typedef struct packed {
        logic       ok;
        logic [5:0] bits;
    } t_lane_res;

    // One decoded result
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  consumed;
        logic        replaced;
    } t_dec_res;

    // Sequence length claimed by the lead byte
    function automatic logic [2:0] claimed_len(input logic [7:0] lead);
        logic [2:0] len;
        if (lead < 8'hC0)      len = 3'd1;
        else if (lead < 8'hE0) len = 3'd2;
        else if (lead < 8'hF0) len = 3'd3;
        else if (lead < 8'hF8) len = 3'd4;
        else if (lead < 8'hFC) len = 3'd5;
        else                   len = 3'd6;
        return len;
    endfunction

    // Lower bound of the second byte, narrowed after some leads
    function automatic logic [7:0] second_lo(input logic [7:0] lead);
        logic [7:0] lo;
        if (lead == LEAD_E0)      lo = TRAIL_LO_E0;
        else if (lead == LEAD_F0) lo = TRAIL_LO_F0;
        else                      lo = TRAIL_LO;
        return lo;
    endfunction

    // Upper bound of the second byte, narrowed after some leads
    function automatic logic [7:0] second_hi(input logic [7:0] lead);
        logic [7:0] hi;
        if (lead == LEAD_ED)      hi = TRAIL_HI_ED;
        else if (lead == LEAD_F4) hi = TRAIL_HI_F4;
        else                      hi = TRAIL_HI;
        return hi;
    endfunction

endpackage

// ----- hw/rtl/u8wd_lane.sv -----
module u8wd_lane
    import u8wd_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic [7:0] i_lo,
    input  logic [7:0] i_hi,
    output t_lane_res  o_res
);

    // Check the byte against its bounds and strip the marker bits
    always_comb begin
        o_res.ok   = (i_byte >= i_lo) && (i_byte <= i_hi);
        o_res.bits = i_byte[5:0];
    end

endmodule

// ----- hw/rtl/u8wd_merge.sv -----
module u8wd_merge
    import u8wd_pkg::*;
(
    input  logic [7:0]             i_lead,
    input  logic [2:0]             i_bytes_left,
    input  t_lane_res [NUM_LANES-1:0] i_lanes,
    output t_dec_res               o_res
);

    logic [2:0]  len;
    logic [20:0] cp;
    logic        bad_lead;

    // Assemble the scalar value for the claimed length
    always_comb begin
        len      = claimed_len(i_lead);
        bad_lead = (i_lead >= CONT_FIRST) && (i_lead < LEAD_MIN_OK);
        case (len)
            3'd1:    cp = {13'd0, i_lead};
            3'd2:    cp = {10'd0, i_lead[4:0], i_lanes[0].bits};
            3'd3:    cp = {5'd0, i_lead[3:0], i_lanes[0].bits, i_lanes[1].bits};
            default: cp = {i_lead[2:0], i_lanes[0].bits, i_lanes[1].bits,
                           i_lanes[2].bits};
        endcase
    end

    // Pick the outcome, checking trailers from the back toward the lead
    always_comb begin
        o_res.code_point = REPLACEMENT_CHAR;
        o_res.replaced   = 1'b1;
        o_res.consumed   = len;
        if (len > i_bytes_left) begin
            o_res.consumed = i_bytes_left;
        end else if (len > 3'd4) begin
            o_res.consumed = len;
        end else if (len == 3'd4 && !i_lanes[2].ok) begin
            o_res.consumed = 3'd3;
        end else if (len >= 3'd3 && !i_lanes[1].ok) begin
            o_res.consumed = 3'd2;
        end else if (len >= 3'd2 && !i_lanes[0].ok) begin
            o_res.consumed = 3'd1;
        end else if (bad_lead) begin
            o_res.consumed = 3'd1;
        end else if (i_lead > LEAD_MAX_OK) begin
            o_res.consumed = len;
        end else if (cp > MAX_SCALAR || (cp >= SURR_LO && cp <= SURR_HI)) begin
            o_res.consumed = len;
        end else begin
            o_res.code_point = cp;
            o_res.replaced   = 1'b0;
        end
    end

endmodule

// ----- hw/rtl/utf8_window_decoder.sv -----
// UTF-8 window decoder.
// Input: pulse start with a four-byte window (i_first_byte .. i_fourth_byte)
// and i_bytes_left, the count of bytes remaining in the text (saturated).
// busy is always low, so a new window may be started in every cycle.
// Output: in the cycle after each accepted start, o_strobe is high for exactly
// one cycle with o_code_point, o_bytes_consumed and o_replaced. Errors give
// U+FFFD with o_replaced set; o_bytes_consumed tells how far to advance.
// Throughput is 1 window per cycle: three trailer lanes check bytes two to four
// side by side, the merge logic combines them, and a single output register
// holds the result.
// The receiver cannot stall; a result not taken in its strobe cycle is lost,
// and the next result follows right behind it.
// Reset (i_rst_n low, synchronous) clears the strobe; no result is pending
// after reset.
module utf8_window_decoder
    import u8wd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_first_byte,
    input  logic [7:0]  i_second_byte,
    input  logic [7:0]  i_third_byte,
    input  logic [7:0]  i_fourth_byte,
    input  logic [2:0]  i_bytes_left,
    output logic        o_strobe,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_bytes_consumed,
    output logic        o_replaced
);

    logic [7:0]                lane_byte [NUM_LANES];
    logic [7:0]                lane_lo   [NUM_LANES];
    logic [7:0]                lane_hi   [NUM_LANES];
    t_lane_res [NUM_LANES-1:0] lane_res;
    t_dec_res                  dec;

    logic     r_strobe;
    t_dec_res r_res;

    // Route trailer bytes and their bounds to the lanes
    always_comb begin
        lane_byte[0] = i_second_byte;
        lane_byte[1] = i_third_byte;
        lane_byte[2] = i_fourth_byte;
        lane_lo[0]   = second_lo(i_first_byte);
        lane_hi[0]   = second_hi(i_first_byte);
        lane_lo[1]   = TRAIL_LO;
        lane_hi[1]   = TRAIL_HI;
        lane_lo[2]   = TRAIL_LO;
        lane_hi[2]   = TRAIL_HI;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        u8wd_lane u_lane (
            .i_byte (lane_byte[g]),
            .i_lo   (lane_lo[g]),
            .i_hi   (lane_hi[g]),
            .o_res  (lane_res[g])
        );
    end

    u8wd_merge u_merge (
        .i_lead       (i_first_byte),
        .i_bytes_left (i_bytes_left),
        .i_lanes      (lane_res),
        .o_res        (dec)
    );

    // Strobe in the cycle after each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= start;
        end
    end

    // Hold the decoded result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_res <= dec;
        end
    end

    assign busy             = 1'b0;
    assign o_strobe         = r_strobe;
    assign o_code_point     = r_res.code_point;
    assign o_bytes_consumed = r_res.consumed;
    assign o_replaced       = r_res.replaced;

`ifndef SYNTH
    a_strobe_follows: assert property (@(posedge i_clk)
        i_rst_n && start |=> o_strobe) else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk)
        i_rst_n && !start |=> !o_strobe) else $error("result without beat");

    a_replaced_fffd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_replaced |-> o_code_point == REPLACEMENT_CHAR)
        else $error("replacement flag without U+FFFD");

    a_good_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_replaced |-> o_code_point <= MAX_SCALAR &&
        (o_code_point < SURR_LO || o_code_point > SURR_HI) &&
        o_bytes_consumed >= 3'd1 && o_bytes_consumed <= 3'd4)
        else $error("accepted sequence is not a scalar value");
`endif

endmodule

// ----- tb/utf8_window_decoder_tb.sv -----
module utf8_window_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8wd_pkg::*;

    localparam int RANDOM_WINDOWS = 1650;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 4;

    // Window category codes for the random part
    typedef enum int {
        WIN_WELL_FORMED,
        WIN_NARROW_LEAD,
        WIN_BROKEN,
        WIN_NOISE
    } t_win_kind;

    // Predict each decode and compare against the result beats
    class decode_checker;
        t_dec_res pending_decodes[$];
        int       mismatches = 0;

        function t_dec_res decode_window(input logic [7:0] lead, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] left);
            logic [7:0]  win [4];
            logic [2:0]  len;
            logic [2:0]  used;
            logic [20:0] cp;
            logic [7:0]  lo;
            logic [7:0]  hi;
            logic        ok;
            t_dec_res    res;
            int          k;
            win[0] = lead;
            win[1] = b1;
            win[2] = b2;
            win[3] = b3;
            // Length from the run of leading ones
            if (lead[7:6] != 2'b11) len = 3'd1;
            else if (!lead[5])      len = 3'd2;
            else if (!lead[4])      len = 3'd3;
            else if (!lead[3])      len = 3'd4;
            else if (!lead[2])      len = 3'd5;
            else                    len = 3'd6;
            cp   = REPLACEMENT_CHAR;
            ok   = 1'b0;
            used = len;
            if (len > left) begin
                used = left;
            end else if (len <= 3'd4) begin
                ok = 1'b1;
                // Walk trailers from the back; the highest failing byte wins
                for (k = len; k > 2; k--) begin
                    if (ok && (win[k-1] < TRAIL_LO || win[k-1] > TRAIL_HI)) begin
                        used = 3'(k - 1);
                        ok   = 1'b0;
                    end
                end
                if (ok && len >= 3'd2) begin
                    lo = TRAIL_LO;
                    hi = TRAIL_HI;
                    case (lead)
                        LEAD_E0: lo = TRAIL_LO_E0;
                        LEAD_ED: hi = TRAIL_HI_ED;
                        LEAD_F0: lo = TRAIL_LO_F0;
                        LEAD_F4: hi = TRAIL_HI_F4;
                        default: ;
                    endcase
                    if (b1 < lo || b1 > hi) begin
                        used = 3'd1;
                        ok   = 1'b0;
                    end
                end
                // Stray continuation or overlong two-byte lead
                if (ok && lead >= CONT_FIRST && lead < LEAD_MIN_OK) begin
                    used = 3'd1;
                    ok   = 1'b0;
                end
                if (ok && lead > LEAD_MAX_OK) ok = 1'b0;
                if (ok) begin
                    case (len)
                        3'd1:    cp = {13'd0, lead};
                        3'd2:    cp = {10'd0, lead[4:0], b1[5:0]};
                        3'd3:    cp = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
                        default: cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
                    endcase
                    if (cp > MAX_SCALAR || (cp >= SURR_LO && cp <= SURR_HI)) begin
                        cp = REPLACEMENT_CHAR;
                        ok = 1'b0;
                    end
                end
            end
            res.code_point = cp;
            res.consumed   = used;
            res.replaced   = !ok;
            return res;
        endfunction

        function void note_window(input logic [7:0] lead, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [2:0] left);
            pending_decodes.push_back(decode_window(lead, b1, b2, b3, left));
        endfunction

        function void check_decode(input logic [20:0] cp, input logic [2:0] used,
                                   input logic repl);
            t_dec_res want;
            if (pending_decodes.size() == 0) begin
                $error("result beat with no window pending");
                mismatches++;
                return;
            end
            want = pending_decodes.pop_front();
            if (cp !== want.code_point) begin
                $error("code_point: expected %h, got %h", want.code_point, cp);
                mismatches++;
            end
            if (used !== want.consumed) begin
                $error("bytes_consumed: expected %0d, got %0d", want.consumed, used);
                mismatches++;
            end
            if (repl !== want.replaced) begin
                $error("replaced: expected %b, got %b", want.replaced, repl);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic [7:0]  i_first_byte     = 8'h00;
    logic [7:0]  i_second_byte    = 8'h00;
    logic [7:0]  i_third_byte     = 8'h00;
    logic [7:0]  i_fourth_byte    = 8'h00;
    logic [2:0]  i_bytes_left     = 3'd0;
    logic        busy;
    logic        o_strobe;
    logic [20:0] o_code_point;
    logic [2:0]  o_bytes_consumed;
    logic        o_replaced;

    decode_checker book;
    int            cycle_count = 0;

    utf8_window_decoder u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_byte     (i_first_byte),
        .i_second_byte    (i_second_byte),
        .i_third_byte     (i_third_byte),
        .i_fourth_byte    (i_fourth_byte),
        .i_bytes_left     (i_bytes_left),
        .o_strobe         (o_strobe),
        .o_code_point     (o_code_point),
        .o_bytes_consumed (o_bytes_consumed),
        .o_replaced       (o_replaced)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Check result beats first, then log the window accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && book != null) begin
            if (o_strobe) book.check_decode(o_code_point, o_bytes_consumed, o_replaced);
            if (start && !busy)
                book.note_window(i_first_byte, i_second_byte, i_third_byte,
                                 i_fourth_byte, i_bytes_left);
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Idle for the gap, present one window, hold until it is taken
    task automatic send_window(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic [2:0] left, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_first_byte  <= b0;
        i_second_byte <= b1;
        i_third_byte  <= b2;
        i_fourth_byte <= b3;
        i_bytes_left  <= left;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Stop sending and wait until every decode has come back
    task automatic drain_decodes();
        start <= 1'b0;
        do @(posedge i_clk); while (book.pending() != 0);
    endtask

    // Build a well-formed sequence for a random scalar value
    task automatic make_scalar_window(output logic [7:0] w0, output logic [7:0] w1,
                                      output logic [7:0] w2, output logic [7:0] w3,
                                      output logic [2:0] len);
        logic [20:0] cp;
        w1 = 8'($urandom_range(0, 255));
        w2 = 8'($urandom_range(0, 255));
        w3 = 8'($urandom_range(0, 255));
        len = 3'($urandom_range(1, 4));
        case (len)
            3'd1: begin
                cp = 21'($urandom_range(0, 'h7F));
                w0 = cp[7:0];
            end
            3'd2: begin
                cp = 21'($urandom_range('h80, 'h7FF));
                w0 = {3'b110, cp[10:6]};
                w1 = {2'b10, cp[5:0]};
            end
            3'd3: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = 21'($urandom_range('hE000, 'hFFFF));
                w0 = {4'b1110, cp[15:12]};
                w1 = {2'b10, cp[11:6]};
                w2 = {2'b10, cp[5:0]};
            end
            default: begin
                cp = 21'($urandom_range('h10000, 'h10FFFF));
                w0 = {5'b11110, cp[20:18]};
                w1 = {2'b10, cp[17:12]};
                w2 = {2'b10, cp[11:6]};
                w3 = {2'b10, cp[5:0]};
            end
        endcase
    endtask

    function automatic int draw_gap(input int idx);
        if ((idx % 160) < 35) return 0;
        return $urandom_range(0, 6);
    endfunction

    initial begin
        logic [7:0] w0;
        logic [7:0] w1;
        logic [7:0] w2;
        logic [7:0] w3;
        logic [2:0] len;
        logic [2:0] left;
        t_win_kind  kind;
        int         pick;
        int         n;

        book = new();

        // Hold reset, then release on an edge
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed windows: extremes, narrowed second bytes, short text, long leads
        send_window(8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 0);
        send_window(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd1, 0);
        send_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2, draw_gap(40));
        send_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd6, draw_gap(40));
        send_window(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2, 0);
        send_window(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd3, 0);
        send_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd1, draw_gap(40));
        send_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3, 0);
        send_window(8'hE0, 8'h9F, 8'h80, 8'h00, 3'd3, 0);
        send_window(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd4, draw_gap(40));
        send_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3, 0);
        send_window(8'hEF, 8'hBF, 8'hBD, 8'h00, 3'd3, 0);
        send_window(8'hEF, 8'hBF, 8'hBF, 8'hFF, 3'd5, draw_gap(40));
        send_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4, 0);
        send_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4, 0);
        send_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4, draw_gap(40));
        send_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4, 0);
        send_window(8'hF5, 8'h80, 8'h80, 8'h80, 3'd4, 0);
        send_window(8'hE2, 8'h82, 8'h41, 8'h00, 3'd3, draw_gap(40));
        send_window(8'hF0, 8'h90, 8'h41, 8'h80, 3'd4, 0);
        send_window(8'hF0, 8'h90, 8'h80, 8'h41, 3'd4, 0);
        send_window(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2, draw_gap(40));
        send_window(8'h41, 8'h00, 8'h00, 8'h00, 3'd0, 0);
        send_window(8'hF8, 8'h80, 8'h80, 8'h80, 3'd5, 0);
        send_window(8'hFC, 8'h80, 8'h80, 8'h80, 3'd6, draw_gap(40));
        send_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 0);

        // Random windows: half well-formed text, the rest narrow-lead, broken or noise
        for (n = 0; n < RANDOM_WINDOWS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      kind = WIN_WELL_FORMED;
            else if (pick < 65) kind = WIN_NARROW_LEAD;
            else if (pick < 85) kind = WIN_BROKEN;
            else                kind = WIN_NOISE;

            make_scalar_window(w0, w1, w2, w3, len);
            case (kind)
                WIN_NARROW_LEAD: begin
                    // Hit the narrowed second-byte ranges around the bounds
                    case ($urandom_range(0, 3))
                        0:       w0 = LEAD_E0;
                        1:       w0 = LEAD_ED;
                        2:       w0 = LEAD_F0;
                        default: w0 = LEAD_F4;
                    endcase
                    w1  = 8'($urandom_range('h80, 'hBF));
                    w2  = 8'($urandom_range('h80, 'hBF));
                    w3  = 8'($urandom_range('h80, 'hBF));
                    len = (w0 >= LEAD_F0) ? 3'd4 : 3'd3;
                end
                WIN_BROKEN: begin
                    // Corrupt one byte of a good sequence
                    case ($urandom_range(0, 3))
                        0:       w0 = 8'($urandom_range(0, 255));
                        1:       w1 = 8'($urandom_range(0, 255));
                        2:       w2 = 8'($urandom_range(0, 255));
                        default: w3 = 8'($urandom_range(0, 255));
                    endcase
                end
                WIN_NOISE: begin
                    w0 = 8'($urandom_range(0, 255));
                    w1 = 8'($urandom_range(0, 255));
                    w2 = 8'($urandom_range(0, 255));
                    w3 = 8'($urandom_range(0, 255));
                end
                default: ;
            endcase

            // Mostly enough text left; sometimes any count, short or empty included
            if (kind == WIN_NOISE || $urandom_range(0, 9) == 0)
                left = 3'($urandom_range(0, 7));
            else
                left = 3'($urandom_range(len, 7));

            send_window(w0, w1, w2, w3, left, draw_gap(n));

            if (n == RANDOM_WINDOWS / 2) drain_decodes();
        end

        // Let the last beats land
        drain_decodes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
